// File: rtl/top5_pkg.sv
// Shared types and constants for the top-5 class selector.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package top5_pkg;

    localparam int SCORE_W         = 16;
    localparam int LABEL_W         = 10;
    localparam int RANK_W          = 3;
    localparam int TOP_K_DEF       = 5;
    localparam int MAX_CLASSES_DEF = 1024;

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic        [LABEL_W-1:0] label_t;
    typedef logic        [RANK_W-1:0]  rank_t;

    typedef struct packed {
        score_t score;
        logic   last_class;
    } in_beat_t;

    typedef struct packed {
        rank_t  rank;
        label_t class_label;
        logic   entry_valid;
        logic   last_rank;
    } out_beat_t;

endpackage

// File: rtl/top5_list.sv
// Sorted best-score list with class counter; one insert per accepted beat.
// Depends on top5_pkg.
`timescale 1ns / 1ps

module top5_list #(
    parameter int TOP_K       = top5_pkg::TOP_K_DEF,
    parameter int MAX_CLASSES = top5_pkg::MAX_CLASSES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  top5_pkg::in_beat_t  in_beat,
    output top5_pkg::label_t    snap_labels [TOP_K],
    output logic                snap_used   [TOP_K]
);

    localparam int CNT_W = $clog2(MAX_CLASSES);

    top5_pkg::score_t scores_reg [TOP_K];
    top5_pkg::score_t scores_next[TOP_K];
    top5_pkg::label_t labels_reg [TOP_K];
    top5_pkg::label_t labels_next[TOP_K];
    logic             used_reg   [TOP_K];
    logic             used_next  [TOP_K];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ge         [TOP_K];
    top5_pkg::label_t new_label;

    assign new_label = top5_pkg::label_t'(count_reg);

    // Entry i gives way when it is empty or not above the new score.
    always_comb begin
        for (int i = 0; i < TOP_K; i++) begin
            ge[i] = !used_reg[i] || (in_beat.score >= scores_reg[i]);
        end
    end

    // Hold above the insert point, drop the new beat in at it, shift below it.
    always_comb begin
        for (int i = 0; i < TOP_K; i++) begin
            if (!ge[i]) begin
                scores_next[i] = scores_reg[i];
                labels_next[i] = labels_reg[i];
                used_next[i]   = used_reg[i];
            end else if (i == 0 || !ge[(i > 0) ? i - 1 : 0]) begin
                scores_next[i] = in_beat.score;
                labels_next[i] = new_label;
                used_next[i]   = 1'b1;
            end else begin
                scores_next[i] = scores_reg[(i > 0) ? i - 1 : 0];
                labels_next[i] = labels_reg[(i > 0) ? i - 1 : 0];
                used_next[i]   = used_reg[(i > 0) ? i - 1 : 0];
            end
        end
        if (count_reg == CNT_W'(MAX_CLASSES - 1)) begin
            count_next = '0;
        end else begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb begin
        for (int i = 0; i < TOP_K; i++) begin
            snap_labels[i] = labels_next[i];
            snap_used[i]   = used_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int i = 0; i < TOP_K; i++) begin
                used_reg[i] <= 1'b0;
            end
        end else if (take) begin
            if (in_beat.last_class) begin
                count_reg <= '0;
                for (int i = 0; i < TOP_K; i++) begin
                    used_reg[i] <= 1'b0;
                end
            end else begin
                count_reg <= count_next;
                for (int i = 0; i < TOP_K; i++) begin
                    used_reg[i] <= used_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            for (int i = 0; i < TOP_K; i++) begin
                scores_reg[i] <= scores_next[i];
                labels_reg[i] <= labels_next[i];
            end
        end
    end

endmodule

// File: rtl/top5_drain.sv
// Result buffer: holds a finished ranking and sends it one rank per beat.
// Depends on top5_pkg.
`timescale 1ns / 1ps

module top5_drain #(
    parameter int TOP_K = top5_pkg::TOP_K_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  top5_pkg::label_t    load_labels [TOP_K],
    input  logic                load_used   [TOP_K],
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output top5_pkg::out_beat_t m_data
);

    localparam int IDX_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;

    top5_pkg::label_t labels_reg [TOP_K];
    logic             used_reg   [TOP_K];
    logic [IDX_W-1:0] idx_reg;
    logic             busy_reg;
    logic             at_end;

    assign at_end  = (idx_reg == IDX_W'(TOP_K - 1));
    assign free    = !busy_reg || (m_ready && at_end);
    assign m_valid = busy_reg;

    always_comb begin
        m_data.rank        = top5_pkg::rank_t'(idx_reg);
        m_data.entry_valid = used_reg[idx_reg];
        m_data.class_label = used_reg[idx_reg] ? labels_reg[idx_reg] : '0;
        m_data.last_rank   = at_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            if (at_end) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < TOP_K; i++) begin
                labels_reg[i] <= load_labels[i];
                used_reg[i]   <= load_used[i];
            end
        end
    end

endmodule

// File: rtl/top5_class_selector.sv
// Top level of the streaming top-K class selector.
// Depends on top5_pkg, top5_list and top5_drain.
`timescale 1ns / 1ps

// Takes one signed class score per beat, in class order, and keeps the TOP_K
// best scores with their class labels (an internal counter, restarting at
// zero for each image and wrapping after MAX_CLASSES - 1). Equal scores rank
// the later class higher. A beat with last_class set is scored like any
// other, then the ranking is sent as TOP_K result beats, rank 0 first, one
// per cycle while m_ready is high, starting the cycle after that beat; ranks
// left empty carry entry_valid 0 and label 0, and the final beat carries
// last_rank. Scoring beats are taken every cycle: the TOP_K parallel compares
// and the list update are combinational between the list registers. The list
// clears as soon as the ranking moves into the result buffer, so the next
// image streams in while results drain. Only a last_class beat can stall,
// and only while the previous ranking is still draining; images of at least
// TOP_K classes therefore never stall when the result side keeps up.

module top5_class_selector #(
    parameter int TOP_K       = top5_pkg::TOP_K_DEF,
    parameter int MAX_CLASSES = top5_pkg::MAX_CLASSES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  top5_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output top5_pkg::out_beat_t m_data
);

    logic             drain_free;
    logic             s_fire;
    logic             load;
    top5_pkg::label_t snap_labels [TOP_K];
    logic             snap_used   [TOP_K];

    // Hold a last beat only while the buffer still owes results.
    assign s_ready = !s_data.last_class || drain_free;
    assign s_fire  = s_valid && s_ready;
    assign load    = s_fire && s_data.last_class;

    top5_list #(
        .TOP_K       (TOP_K),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_list (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (s_fire),
        .in_beat     (s_data),
        .snap_labels (snap_labels),
        .snap_used   (snap_used)
    );

    top5_drain #(
        .TOP_K       (TOP_K)
    ) u_drain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .load_labels (snap_labels),
        .load_used   (snap_used),
        .free        (drain_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // A ranking starts at rank 0 right after its last beat.
    a_run_start: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (m_valid && m_data.rank == '0))
        else $error("result run did not start at rank 0");

    // After the final rank goes out, nothing or a fresh run follows.
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_rank)
            |=> (!m_valid || m_data.rank == '0))
        else $error("result run continued past its final rank");

    // Empty ranks only trail the filled ones.
    a_empty_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.entry_valid && !m_data.last_rank)
            |=> !m_data.entry_valid)
        else $error("filled rank follows an empty one");

endmodule

// File: tb/tb_top5_class_selector.sv
// Self-checking testbench for top5_class_selector: streams class scores per image
// and checks each ranked result beat against an in-bench ranking predictor.
// Depends on rtl/top5_pkg.sv and rtl/top5_class_selector.sv.
`timescale 1ns / 1ps

module tb_top5_class_selector;

    localparam int TOP_K          = top5_pkg::TOP_K_DEF;
    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 12;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 20;
    localparam int CYCLE_LIMIT    = 100000;
    localparam int PHASE_BEATS    = 26;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    top5_pkg::in_beat_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    top5_pkg::out_beat_t m_data;

    top5_class_selector uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Beats waiting to be offered, and ranking beats the block still owes us.
    top5_pkg::in_beat_t  pending_scores[$];
    top5_pkg::out_beat_t expected_ranks[$];

    // Backpressure knobs, written by the stimulus process at the falling edge.
    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    int hold_requested = 0;

    // Owned by the receiver process.
    int                  hold_granted    = 0;
    int                  hold_left       = 0;
    int                  mismatches      = 0;
    int                  results_checked = 0;
    top5_pkg::out_beat_t oldest_rank;

    int cycle_count = 0;
    int beats_sent  = 0;
    int images_sent = 0;

    // Predictor state: the best TOP_K scores, best first, plus the label counter.
    top5_pkg::score_t top_score[TOP_K];
    top5_pkg::label_t top_label[TOP_K];
    logic             top_used[TOP_K];
    top5_pkg::label_t next_label;

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function void clear_ranking();
        for (int i = 0; i < TOP_K; i++) begin
            top_score[i] = '0;
            top_label[i] = '0;
            top_used[i]  = 1'b0;
        end
        next_label = '0;
    endfunction

    // Insert one score ahead of every entry that is less than or equal to it, so
    // the later class wins a tie; on the final class, queue the ranking and clear.
    function void rank_score(top5_pkg::in_beat_t beat);
        int                  pos;
        top5_pkg::out_beat_t r;
        pos = 0;
        while (pos < TOP_K && top_used[pos] && top_score[pos] > beat.score)
            pos++;
        if (pos < TOP_K) begin
            for (int i = TOP_K - 1; i > pos; i--) begin
                top_score[i] = top_score[i - 1];
                top_label[i] = top_label[i - 1];
                top_used[i]  = top_used[i - 1];
            end
            top_score[pos] = beat.score;
            top_label[pos] = next_label;
            top_used[pos]  = 1'b1;
        end
        // The label field spans exactly MAX_CLASSES values, so the counter
        // wraps on its own.
        next_label = next_label + 1'b1;
        if (beat.last_class) begin
            for (int k = 0; k < TOP_K; k++) begin
                r.rank        = top5_pkg::rank_t'(k);
                r.class_label = top_used[k] ? top_label[k] : '0;
                r.entry_valid = top_used[k];
                r.last_rank   = (k == TOP_K - 1);
                expected_ranks = {expected_ranks, r};
            end
            clear_ranking();
        end
    endfunction

    // Driver: predict on each accepted beat, then hold, advance or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            clear_ranking();
        end else begin
            if (s_valid && s_ready)
                rank_score(s_data);
            if (!s_valid || s_ready) begin
                if (pending_scores.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_data  <= pending_scores.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task report_field(input string field, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Receiver: check each accepted result beat against the oldest expectation,
    // then pick m_ready for the next cycle. A requested hold keeps m_ready low
    // for a long stretch so the ranking buffer fills and s_ready drops.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_ranks.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %p",
                             $time, m_data);
                    mismatches++;
                end else begin
                    oldest_rank = expected_ranks.pop_front();
                    report_field("rank", 16'(oldest_rank.rank), 16'(m_data.rank));
                    report_field("class_label", 16'(oldest_rank.class_label),
                                 16'(m_data.class_label));
                    report_field("entry_valid", 16'(oldest_rank.entry_valid),
                                 16'(m_data.entry_valid));
                    report_field("last_rank", 16'(oldest_rank.last_rank),
                                 16'(m_data.last_rank));
                    results_checked++;
                end
            end
            if (hold_left == 0 && hold_granted != hold_requested) begin
                hold_left    = RX_HOLD_CYCLES;
                hold_granted = hold_requested;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task add_beat(input top5_pkg::score_t score, input logic last);
        top5_pkg::in_beat_t b;
        b.score      = score;
        b.last_class = last;
        pending_scores = {pending_scores, b};
        beats_sent++;
        if (last)
            images_sent++;
    endtask

    // One image of random scores: wide random, a narrow band full of ties,
    // or a mix of the signed extremes, zero and minus one.
    task queue_image(input int n_classes);
        int               style;
        top5_pkg::score_t s;
        style = $urandom_range(2);
        for (int i = 0; i < n_classes; i++) begin
            case (style)
                0: begin
                    s = top5_pkg::score_t'($urandom);
                end
                1: begin
                    s = top5_pkg::score_t'(int'($urandom_range(6)) - 3);
                end
                default: begin
                    case ($urandom_range(3))
                        0:       s = 16'sh7FFF;
                        1:       s = 16'sh8000;
                        2:       s = '0;
                        default: s = '1;
                    endcase
                end
            endcase
            add_beat(s, i == n_classes - 1);
        end
    endtask

    // Stop sending until every owed ranking beat has come back.
    task wait_drained();
        do
            @(negedge aclk);
        while (pending_scores.size() != 0 || s_valid || expected_ranks.size() != 0);
    endtask

    initial begin
        int tx_mix[4];
        int rx_mix[4];
        int queued;
        int n;
        tx_mix = '{0, 65, 0, 31};
        rx_mix = '{0, 0, 65, 31};
        wait (aresetn);
        @(negedge aclk);

        // Directed: a lone class at the most negative score, leaving four ranks empty.
        add_beat(16'sh8000, 1'b1);
        // Two maximal scores that tie: the later class must rank first.
        add_beat(16'sh7FFF, 1'b0);
        add_beat(16'sh7FFF, 1'b1);
        // Eight classes: ties, both extremes, and low scores dropped once the list is full.
        add_beat(16'sd100, 1'b0);
        add_beat(16'sd100, 1'b0);
        add_beat(16'sh8000, 1'b0);
        add_beat(16'sh7FFF, 1'b0);
        add_beat(16'sd5, 1'b0);
        add_beat(16'sd100, 1'b0);
        add_beat(-16'sd5, 1'b0);
        add_beat(16'sd50, 1'b1);
        // Six equal scores: every new one displaces the older ones.
        for (int i = 0; i < 6; i++)
            add_beat('0, i == 5);
        // Alternating bit patterns on the score.
        add_beat(16'sh5555, 1'b0);
        add_beat(16'shAAAA, 1'b1);
        wait_drained();

        // Random images under four backpressure mixes, draining between mixes.
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = tx_mix[ph];
            rx_stall_pct = rx_mix[ph];
            if (ph == 0) begin
                // Stall the result side while short images keep arriving, so
                // a final-class beat has to wait on the draining ranking.
                hold_requested++;
                for (int i = 0; i < 12; i++)
                    queue_image($urandom_range(1, 3));
            end
            queued = 0;
            while (queued < PHASE_BEATS) begin
                n = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                queue_image(n);
                queued += n;
            end
            wait_drained();
        end

        // Let any stray beat show up before the verdict.
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("Sent %0d score beats in %0d images; checked %0d ranking beats", beats_sent,
                 images_sent, results_checked);
        $display("under four backpressure mixes and a long result stall.");
        if (mismatches == 0 && expected_ranks.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
rtl/top5_pkg.sv
rtl/top5_list.sv
rtl/top5_drain.sv
rtl/top5_class_selector.sv
tb/tb_top5_class_selector.sv
